FILE: rtl/slrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slrd_pkg;

   // Shuffle table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int WARMUP      = TABLE_DEPTH + 8;
   localparam int STEP_W      = $clog2(WARMUP);

   // Lehmer generator constants
   localparam int             VAL_W   = 31;
   localparam logic [30:0]    LEH_MOD = 31'h7FFF_FFFF;
   localparam int             MUL_W   = 15;
   localparam logic [14:0]    LEH_MUL = 15'd16807;
   localparam int             MBIT_W  = $clog2(MUL_W);

   // Slot divisor: previous output over this gives the table slot
   localparam longint unsigned SLOT_DIV = 1 + (64'h7FFF_FFFE / TABLE_DEPTH);

   // Ranged draw arithmetic
   localparam int          DATA_W    = 32;
   localparam int          DBIT_W    = $clog2(DATA_W);
   localparam logic [31:0] RANGE_TOP = 32'h7FFF_FFFF;
   localparam logic [31:0] POW31     = 32'h8000_0000;

   // Request kinds
   localparam logic ACT_RAW   = 1'b0;
   localparam logic ACT_RANGE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LIMIT,
      ST_DRAW,
      ST_WARM,
      ST_STEP,
      ST_POST,
      ST_MOD,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/shuffled_lehmer_random_draw.sv
// Shuffled Lehmer random draw: minimal-standard generator (x * 16807 mod 2^31-1)
// behind a 32-entry shuffle table.
// Request channel (req_*): one beat per draw. tuser = action (0 raw, 1 ranged),
// tdata = range_low in [31:0], range_high in [63:32].
// Response channel (rsp_*): one beat per request, tdata = the 32-bit value.
// csr_wr_en/csr_wr_data load the seed; the next draw re-initializes the table.
// Each generator step is a bit-serial modular multiply, one bit of the
// constant 16807 per cycle. The first draw after reset or a seed write adds 40
// warm-up steps. A ranged draw adds two bit-serial remainder passes, plus a
// further generator step per rejected draw. A single-value, empty or oversized
// range answers range_low.
// One request is in work at a time; req_tready is high only while the engine
// is idle. A finished response waits in the output register, so the next
// request is accepted while it is held; the engine stalls at the end of a
// request only if the previous response has not yet been taken.
// Reset (synchronous, active high) clears the generator to the
// needs-initialization state; the next draw starts from seed 1.
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lehmer_random_draw import slrd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] range_low, [63:32] range_high
   input  wire logic [0:0]  req_tuser,   // [0] action
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] value
   // seed register
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   // control registers
   state_type           state_ff, state_in;
   logic [MBIT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [STEP_W-1:0]   step_cnt_ff, step_cnt_in;
   logic [DBIT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [VAL_W-1:0]    gen_ff, gen_in;
   logic [VAL_W-1:0]    out_ff, out_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic                action_ff, action_in;
   logic [31:0]         lo_ff, lo_in;
   logic [31:0]         span_ff, span_in;
   logic [31:0]         limit_ff, limit_in;
   logic [VAL_W-1:0]    acc_ff, acc_in;
   logic [31:0]         div_rem_ff, div_rem_in;
   logic [31:0]         div_dvd_ff, div_dvd_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [31:0]         res_ff, res_in;
   logic [31:0]         rsp_data_ff, rsp_data_in;

   // shuffle table
   logic [VAL_W-1:0]    shuffle_mem [TABLE_DEPTH];
   logic [VAL_W-1:0]    mem_rdata_ff;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [VAL_W-1:0]    mem_wdata;

   // datapath helpers
   logic                req_accept, rsp_free, mul_last, div_last;
   logic                range_ok, reject;
   logic [VAL_W-1:0]    acc_dbl, acc_step;
   logic [VAL_W:0]      acc_sum;
   logic [32:0]         div_trial, div_diff;
   logic [31:0]         div_rem_next;
   logic [31:0]         seed_mag;
   logic [VAL_W-1:0]    seed_gen;
   logic [VAL_W-1:0]    slot_wide;
   logic [ADDR_W-1:0]   slot_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign mul_last   = (bit_cnt_ff == '0);
   assign div_last   = (div_cnt_ff == '0);

   // one bit of the multiplier per cycle: acc = 2*acc (+ x) mod 2^31-1
   assign acc_dbl  = {acc_ff[VAL_W-2:0], acc_ff[VAL_W-1]};
   assign acc_sum  = {1'b0, acc_dbl} + (LEH_MUL[bit_cnt_ff] ? {1'b0, gen_ff} : '0);
   assign acc_step = (acc_sum >= {1'b0, LEH_MOD}) ? acc_sum[VAL_W-1:0] - LEH_MOD
                                                 : acc_sum[VAL_W-1:0];

   // restoring remainder, one dividend bit per cycle
   assign div_trial    = {div_rem_ff, div_dvd_ff[31]};
   assign div_diff     = div_trial - {1'b0, span_ff};
   assign div_rem_next = div_diff[32] ? div_trial[31:0] : div_diff[31:0];

   // seed magnitude folded below the modulus
   assign seed_mag = csr_wr_data[31] ? (~csr_wr_data + 32'd1) : csr_wr_data;
   assign seed_gen = (seed_mag >= {1'b0, LEH_MOD}) ? 31'(seed_mag - {1'b0, LEH_MOD})
                                                  : seed_mag[VAL_W-1:0];

   // table slot from the previous output
   assign slot_wide = out_ff / VAL_W'(SLOT_DIV);
   assign slot_calc = (slot_wide > VAL_W'(TABLE_DEPTH - 1)) ? ADDR_W'(TABLE_DEPTH - 1)
                                                          : slot_wide[ADDR_W-1:0];

   // span of 2 .. 2^31 can be drawn; anything else answers the low bound
   assign range_ok = (span_ff >= 32'd2) && (span_ff <= POW31);
   assign reject   = ({1'b0, out_ff} > limit_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_CHECK;
         ST_CHECK: begin
            if (action_ff == ACT_RAW) state_in = ST_DRAW;
            else if (!range_ok)       state_in = ST_EMIT;
            else                      state_in = ST_LIMIT;
         end
         ST_LIMIT: if (div_last) state_in = ST_DRAW;
         ST_DRAW:  state_in = (out_ff == '0) ? ST_WARM : ST_STEP;
         ST_WARM:  if (mul_last && step_cnt_ff == '0) state_in = ST_DRAW;
         ST_STEP:  if (mul_last) state_in = ST_POST;
         ST_POST: begin
            if (action_ff == ACT_RAW) state_in = ST_EMIT;
            else if (reject)          state_in = ST_DRAW;
            else                      state_in = ST_MOD;
         end
         ST_MOD:   if (div_last) state_in = ST_EMIT;
         ST_EMIT:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      bit_cnt_in   = bit_cnt_ff;
      step_cnt_in  = step_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      gen_in       = gen_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      action_in    = action_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      limit_in     = limit_ff;
      acc_in       = acc_ff;
      div_rem_in   = div_rem_ff;
      div_dvd_in   = div_dvd_ff;
      slot_in      = slot_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = slot_ff;
      mem_raddr    = slot_calc;
      mem_wdata    = acc_step;

      // response beat taken
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      // seed write: load magnitude, force re-initialization
      if (csr_wr_en) begin
         gen_in = seed_gen;
         out_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               action_in = req_tuser[0];
               lo_in     = req_tdata[31:0];
               span_in   = req_tdata[63:32] - req_tdata[31:0] + 32'd1;
            end
         end
         ST_CHECK: begin
            res_in     = lo_ff;
            div_rem_in = '0;
            div_dvd_in = POW31;
            div_cnt_in = DBIT_W'(DATA_W - 1);
         end
         ST_LIMIT: begin
            div_rem_in = div_rem_next;
            div_dvd_in = {div_dvd_ff[30:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_last) limit_in = RANGE_TOP - div_rem_next;
         end
         ST_DRAW: begin
            acc_in     = '0;
            bit_cnt_in = MBIT_W'(MUL_W - 1);
            if (out_ff == '0) begin
               gen_in      = (gen_ff == '0) ? VAL_W'(1) : gen_ff;
               step_cnt_in = STEP_W'(WARMUP - 1);
            end else begin
               slot_in = slot_calc;
               mem_re  = 1'b1;
            end
         end
         ST_WARM: begin
            acc_in     = acc_step;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (mul_last) begin
               gen_in = acc_step;
               if (step_cnt_ff < STEP_W'(TABLE_DEPTH)) begin
                  mem_we    = 1'b1;
                  mem_waddr = step_cnt_ff[ADDR_W-1:0];
               end
               if (step_cnt_ff == '0) begin
                  out_in = acc_step;
               end else begin
                  step_cnt_in = step_cnt_ff - 1'b1;
                  acc_in      = '0;
                  bit_cnt_in  = MBIT_W'(MUL_W - 1);
               end
            end
         end
         ST_STEP: begin
            acc_in     = acc_step;
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (mul_last) begin
               gen_in = acc_step;
               out_in = mem_rdata_ff;
               mem_we = 1'b1;
            end
         end
         ST_POST: begin
            res_in     = {1'b0, out_ff};
            div_rem_in = '0;
            div_dvd_in = {1'b0, out_ff};
            div_cnt_in = DBIT_W'(DATA_W - 1);
         end
         ST_MOD: begin
            div_rem_in = div_rem_next;
            div_dvd_in = {div_dvd_ff[30:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_last) res_in = lo_ff + div_rem_next;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         step_cnt_ff  <= '0;
         div_cnt_ff   <= '0;
         gen_ff       <= '0;
         out_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         step_cnt_ff  <= step_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         gen_ff       <= gen_in;
         out_ff       <= out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      limit_ff    <= limit_in;
      acc_ff      <= acc_in;
      div_rem_ff  <= div_rem_in;
      div_dvd_ff  <= div_dvd_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // shuffle table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) shuffle_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= shuffle_mem[mem_raddr];
   end

`ifndef ASSERT_OFF
   // generator never sits on the fixed point at the modulus
   assert property (@(posedge clock) disable iff (reset) gen_ff != LEH_MOD)
      else $error("generator reached the modulus");

   // partial product stays reduced while multiplying
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WARM || state_ff == ST_STEP) |-> acc_ff != LEH_MOD)
      else $error("multiply accumulator out of range");

   // a shuffle step only runs on an initialized table
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> out_ff != '0)
      else $error("shuffle step without initialization");

   // remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIMIT || state_ff == ST_MOD) |-> div_rem_ff < span_ff)
      else $error("remainder not reduced");

   // a ranged draw is only taken within the acceptance limit
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && action_ff == ACT_RANGE && !reject) |=> state_ff == ST_MOD)
      else $error("accepted draw did not reduce");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import slrd_pkg::*;

   localparam int  RUN_LIMIT    = 1_000_000;
   localparam int  RANDOM_ITEMS = 930;
   localparam int  SETTLE       = 40;

   // Request payload as it sits on req_tdata
   typedef struct packed {
      logic [31:0] range_high;
      logic [31:0] range_low;
   } draw_req_type;

   // Predictor and store of expected values for the draw engine
   class draw_scoreboard;
      logic [30:0] gen_value;
      logic [30:0] shuffle_out;
      logic [30:0] shuffle_tab [TABLE_DEPTH];
      logic [31:0] expected_values [$];
      int          errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         gen_value   = '0;
         shuffle_out = '0;
      endfunction

      function void load_seed(logic [31:0] seed);
         logic [31:0] mag;
         mag = seed[31] ? (~seed + 32'd1) : seed;
         gen_value   = 31'(mag % 32'h7FFF_FFFF);
         shuffle_out = '0;
      endfunction

      function logic [30:0] lehmer_step(logic [30:0] x);
         longint unsigned prod;
         prod = longint'(x) * longint'(LEH_MUL);
         return 31'(prod % longint'(LEH_MOD));
      endfunction

      // One shuffled generator output; warms up the table when due
      function logic [30:0] shuffled_draw();
         int          slot;
         logic [30:0] picked;
         if (shuffle_out == 0) begin
            if (gen_value == 0) gen_value = 31'd1;
            for (int i = WARMUP - 1; i >= 0; i--) begin
               gen_value = lehmer_step(gen_value);
               if (i < TABLE_DEPTH) shuffle_tab[i] = gen_value;
            end
            shuffle_out = shuffle_tab[0];
         end
         gen_value = lehmer_step(gen_value);
         slot = int'(longint'(shuffle_out) / SLOT_DIV);
         if (slot > TABLE_DEPTH - 1) slot = TABLE_DEPTH - 1;
         picked = shuffle_tab[slot];
         shuffle_tab[slot] = gen_value;
         shuffle_out = picked;
         return picked;
      endfunction

      // Accepted request beat: work out the value it must return
      function void note_request(logic action, draw_req_type req);
         logic [31:0] span;
         logic [31:0] limit;
         logic [31:0] n;
         logic [31:0] value;
         if (action == ACT_RAW) begin
            value = {1'b0, shuffled_draw()};
         end else begin
            span = req.range_high - req.range_low + 32'd1;
            if (span <= 32'd1 || (span - 32'd1) > RANGE_TOP) begin
               value = req.range_low;
            end else begin
               limit = RANGE_TOP - (POW31 % span);
               do begin
                  n = {1'b0, shuffled_draw()};
               end while (n > limit);
               value = req.range_low + n % span;
            end
         end
         expected_values.push_back(value);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      // Accepted response beat: compare with the oldest expectation
      task check_response(logic [31:0] got);
         logic [31:0] want;
         if (expected_values.size() == 0) begin
            report_mismatch("unexpected response", got, 32'h0);
         end else begin
            want = expected_values.pop_front();
            if (got !== want) report_mismatch("value", got, want);
         end
      endtask

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   draw_scoreboard sb;
   bit             no_idle;
   int             cycle_count;

   shuffled_lehmer_random_draw DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Drive one request beat, holding valid across back-to-back beats
   task send_request(logic action, logic [31:0] lo, logic [31:0] hi);
      int           gap;
      draw_req_type req;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      req.range_low  = lo;
      req.range_high = hi;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= req;
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, req);
   endtask

   // Drop valid and wait for every outstanding beat to come back
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_seed(logic [31:0] seed);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= seed;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.load_seed(seed);
   endtask

   task random_request();
      int unsigned pick;
      logic [31:0] lo;
      logic [31:0] span;
      pick = $urandom_range(0, 99);
      lo   = $urandom;
      if (pick < 35) begin
         send_request(ACT_RAW, lo, $urandom);
      end else if (pick < 65) begin
         span = $urandom_range(2, 1000);
         send_request(ACT_RANGE, lo, lo + span - 32'd1);
      end else if (pick < 80) begin
         span = $urandom_range(2, 32'h8000_0000);
         send_request(ACT_RANGE, lo, lo + span - 32'd1);
      end else if (pick < 92) begin
         send_request(ACT_RANGE, lo, $urandom);
      end else begin
         // degenerate ranges: single value, empty, oversized
         case ($urandom_range(0, 2))
            0: send_request(ACT_RANGE, lo, lo);
            1: send_request(ACT_RANGE, lo, lo - 32'd1);
            default: send_request(ACT_RANGE, lo,
                                  lo + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFE));
         endcase
      end
   endtask

   task directed_requests();
      send_request(ACT_RAW,   32'h0000_0000, 32'h0000_0000);
      send_request(ACT_RAW,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_RANGE, 32'h0000_0005, 32'h0000_0005);
      send_request(ACT_RANGE, 32'h0000_0005, 32'h0000_0004);
      send_request(ACT_RANGE, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(ACT_RANGE, 32'h0000_0000, 32'h7FFF_FFFF);
      send_request(ACT_RANGE, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(ACT_RANGE, 32'h0000_0000, 32'h8000_0000);
      send_request(ACT_RANGE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(ACT_RANGE, 32'h7FFF_FFFF, 32'h8000_0005);
      send_request(ACT_RANGE, 32'h0000_0000, 32'h4000_0000);
      send_request(ACT_RANGE, 32'h8000_0000, 32'h8000_0001);
      send_request(ACT_RANGE, 32'h0000_0001, 32'h0000_0006);
      send_request(ACT_RANGE, 32'hFFFF_FF9C, 32'h0000_0064);
      send_request(ACT_RANGE, 32'h7FFF_FFFA, 32'h7FFF_FFFF);
      send_request(ACT_RANGE, 32'h0000_0000, 32'hFFFF_FFFE);
      send_request(ACT_RANGE, 32'h0000_000A, 32'h0000_0000);
      send_request(ACT_RANGE, 32'hC000_0000, 32'h0000_0000);
      send_request(ACT_RAW,   32'h1234_5678, 32'h9ABC_DEF0);
      send_request(ACT_RAW,   32'h0000_0000, 32'h0000_0000);
   endtask

   // Response side
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata);
      end
   end

   // Main sequence
   initial begin
      logic [31:0] seeds [10];
      int          per_phase;
      sb          = new();
      clock       = 1'b0;
      reset       = 1'b1;
      cycle_count = 0;
      no_idle     = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      seeds = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFE, 32'h0000_0000,
                $urandom, $urandom};
      per_phase = RANDOM_ITEMS / $size(seeds);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Phase 0 runs from the reset state without a seed write
      for (int p = 0; p < $size(seeds); p++) begin
         if (p > 0) write_seed(seeds[p]);
         no_idle = (p == 3);
         if (p == 0) directed_requests();
         for (int i = 0; i < per_phase; i++) begin
            // in phase 5 only, let the pipe run dry once mid-phase before going on
            if (p == 5 && i == per_phase / 2) begin
               drain();
               @(posedge clock);
            end
            random_request();
         end
         drain();
      end

      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/slrd_pkg.sv
rtl/shuffled_lehmer_random_draw.sv
tb/tb.sv
